// File: src/adc_scan_oversample_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// ADC scan sequencer assertion macros
// Property forms for the checker of the scan sequencer.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_OVERSAMPLE_SEQUENCER_UNIT_MACROS_SVH
`define ADC_SCAN_OVERSAMPLE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/adc_sos_pkg.sv
// ----------------------------------------------------------------------------
// ADC scan sequencer package
// Widths, register and mode codes, and the layout of the stream words.
// ----------------------------------------------------------------------------
package adc_sos_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int SAMPLE_W     = 10;
    localparam int ACC_W        = 16;
    localparam int CNT_W        = 5;
    localparam int OSC_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MODE_W       = 2;

    // input word: sample, read_index
    localparam int S_TDATA_W    = 16;
    localparam int S_SAMPLE_LSB = 0;
    localparam int S_RIDX_LSB   = 10;

    // output word: mux_index, start_conversion, cycle_done, channel_finished,
    // finished_index, finished_sum, read_value, ignored
    localparam int M_TDATA_W    = 48;
    localparam int M_MUX_LSB    = 0;
    localparam int M_START_BIT  = 4;
    localparam int M_DONE_BIT   = 5;
    localparam int M_FIN_BIT    = 6;
    localparam int M_FIDX_LSB   = 7;
    localparam int M_FSUM_LSB   = 11;
    localparam int M_RVAL_LSB   = 27;
    localparam int M_IGN_BIT    = 43;

    localparam logic [15:0]      RST_ENABLE_MASK = 16'hFFFF;
    localparam logic [OSC_W-1:0] RST_OVERSAMPLE  = 6'd16;
    localparam logic [OSC_W-1:0] OSC_MAX         = 6'd32;
    localparam logic [ACC_W-1:0] SIGN_FILL       = 16'hFC00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_MASK = 2'd0,
        CFG_OVERSAMPLE  = 2'd1,
        CFG_DIFF_ENABLE = 2'd2,
        CFG_DIFF_CHAN   = 2'd3
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

endpackage

// File: src/adc_scan_oversample_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ADC scan oversample sequencer
// Scans enabled channels, sums a set number of conversions per channel in an
// accumulator memory, and reports each finished sum.
// ----------------------------------------------------------------------------
// One item goes in per clock while the output is taken. Every item gives one
// output word, which goes through stage one and a one-word output register
// to the port: the accumulator memory is read at the accepting edge, and
// stage one then adds, writes back and loads the output register. A stalled
// output holds one word there and one in the read stage; the input then stalls.
// Channel selection and sample counting resolve in the cycle an item is taken,
// so back-to-back samples of one channel forward the fresh sum instead of
// waiting on the memory. A start word clears all accumulators at once through
// per-entry valid flags; there is no clearing pass after reset.
module adc_scan_oversample_sequencer_unit #(
    parameter int NUM_CHANNELS = adc_sos_pkg::MAX_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [adc_sos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adc_sos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [adc_sos_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // sample[9:0], read_index[13:10]
    input  logic [adc_sos_pkg::MODE_W-1:0]     i_s_axis_tuser,  // mode[1:0]
    // output words
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // mux_index[3:0], start_conversion[4], cycle_done[5], channel_finished[6],
    // finished_index[10:7], finished_sum[26:11], read_value[42:27], ignored[43]
    output logic [adc_sos_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_W  = adc_sos_pkg::CH_W;
    localparam int ACC_W = adc_sos_pkg::ACC_W;
    localparam int OSC_W = adc_sos_pkg::OSC_W;
    localparam logic [adc_sos_pkg::MAX_CHANNELS-1:0] ChanLim =
        adc_sos_pkg::MAX_CHANNELS'((33'd1 << NUM_CHANNELS) - 33'd1);

    typedef struct packed {
        logic            found;
        logic [CH_W-1:0] idx;
    } t_pick;

    typedef struct packed {
        logic [CH_W-1:0] mux_index;
        logic            start;
        logic            done;
        logic            fin;
        logic [CH_W-1:0] fidx;
        logic            ign;
    } t_ctl;

    function automatic t_pick f_lowest(input logic [adc_sos_pkg::MAX_CHANNELS-1:0] set);
        t_pick p;
        p = '0;
        for (int i = adc_sos_pkg::MAX_CHANNELS - 1; i >= 0; i--) begin
            if (set[i]) begin
                p.found = 1'b1;
                p.idx   = CH_W'(i);
            end
        end
        return p;
    endfunction

    // configuration
    logic [15:0]              r_cfg_mask;
    logic [OSC_W-1:0]         r_cfg_osc;
    logic                     r_cfg_diff_en;
    logic [CH_W-1:0]          r_cfg_diff_ch;

    // scan control
    logic [CH_W-1:0]          r_cur_ch, n_cur_ch;
    logic [adc_sos_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_active, n_active;
    logic [NUM_CHANNELS-1:0]  r_valid;

    // accumulator memory
    logic [ACC_W-1:0]         r_acc_mem [NUM_CHANNELS];
    logic [ACC_W-1:0]         r_acc_q;

    // stage between read and write back
    logic                     r_s1_vld;
    logic                     r_s1_wr, n_s1_wr;
    logic                     r_s1_rd, n_s1_rd;
    logic [AW-1:0]            r_s1_addr, n_s1_addr;
    logic [ACC_W-1:0]         r_s1_add, n_s1_add;
    logic                     r_s1_vbit;
    logic                     r_s1_fwd;
    logic [ACC_W-1:0]         r_s1_fwd_data;
    t_ctl                     r_s1_ctl, n_s1_ctl;

    // output register
    logic                     r_out_vld;
    logic [adc_sos_pkg::M_TDATA_W-1:0] r_out_data;

    logic                     out_free, s1_adv, in_acc, rd_en, in_range;
    logic [adc_sos_pkg::MODE_W-1:0]  in_mode;
    logic [adc_sos_pkg::SAMPLE_W-1:0] in_sample;
    logic [CH_W-1:0]          in_ridx;
    logic [OSC_W-1:0]         target, cnt_nx;
    t_pick                    pick_first, pick_next;
    logic [ACC_W-1:0]         base, sum;
    logic                     fwd_hit;

    assign in_mode   = i_s_axis_tuser;
    assign in_sample = i_s_axis_tdata[adc_sos_pkg::S_SAMPLE_LSB +: adc_sos_pkg::SAMPLE_W];
    assign in_ridx   = i_s_axis_tdata[adc_sos_pkg::S_RIDX_LSB +: CH_W];

    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign s1_adv          = r_s1_vld && out_free;
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign in_range        = (32'(in_ridx) < NUM_CHANNELS);

    assign target = (r_cfg_osc == '0) ? OSC_W'(1) :
                    (r_cfg_osc > adc_sos_pkg::OSC_MAX) ? adc_sos_pkg::OSC_MAX : r_cfg_osc;
    assign cnt_nx = OSC_W'(r_cnt) + OSC_W'(1);

    assign pick_first = f_lowest(r_cfg_mask & ChanLim);
    assign pick_next  = f_lowest(r_cfg_mask & ChanLim &
                                 ~adc_sos_pkg::MAX_CHANNELS'((17'd2 << r_cur_ch) - 17'd1));

    // accumulator value seen by the word in stage one
    assign base = r_s1_fwd  ? r_s1_fwd_data :
                  r_s1_vbit ? r_acc_q       : '0;
    assign sum  = base + r_s1_add;

    // decide control effects of the incoming word
    always_comb begin
        n_cur_ch  = r_cur_ch;
        n_cnt     = r_cnt;
        n_active  = r_active;
        n_s1_wr   = 1'b0;
        n_s1_rd   = 1'b0;
        n_s1_addr = r_cur_ch[AW-1:0];
        n_s1_add  = '0;
        n_s1_ctl  = '0;
        rd_en     = 1'b0;
        unique case (in_mode)
            adc_sos_pkg::MODE_START: begin
                n_cnt = '0;
                if (pick_first.found) begin
                    n_cur_ch       = pick_first.idx;
                    n_active       = 1'b1;
                    n_s1_ctl.start = 1'b1;
                end else begin
                    n_cur_ch      = '0;
                    n_active      = 1'b0;
                    n_s1_ctl.done = 1'b1;
                end
            end
            adc_sos_pkg::MODE_SAMPLE: begin
                if (!r_active) begin
                    n_s1_ctl.ign = 1'b1;
                end else begin
                    rd_en    = 1'b1;
                    n_s1_wr  = 1'b1;
                    n_s1_add = {ACC_W'(in_sample)};
                    if (r_cfg_diff_en && (r_cur_ch == r_cfg_diff_ch) &&
                        in_sample[adc_sos_pkg::SAMPLE_W-1]) begin
                        n_s1_add = adc_sos_pkg::SIGN_FILL | ACC_W'(in_sample);
                    end
                    if (cnt_nx >= target) begin
                        n_s1_ctl.fin  = 1'b1;
                        n_s1_ctl.fidx = r_cur_ch;
                        n_cnt         = '0;
                        if (pick_next.found) begin
                            n_cur_ch       = pick_next.idx;
                            n_s1_ctl.start = 1'b1;
                        end else begin
                            n_active      = 1'b0;
                            n_s1_ctl.done = 1'b1;
                        end
                    end else begin
                        n_cnt          = cnt_nx[adc_sos_pkg::CNT_W-1:0];
                        n_s1_ctl.start = 1'b1;
                    end
                end
            end
            adc_sos_pkg::MODE_READ: begin
                n_s1_rd   = 1'b1;
                n_s1_addr = in_ridx[AW-1:0];
                rd_en     = in_range;
            end
            default: begin
            end
        endcase
        n_s1_ctl.mux_index = n_cur_ch;
    end

    // a write back in the same cycle to the entry being read
    assign fwd_hit = s1_adv && r_s1_wr && rd_en && (r_s1_addr == n_s1_addr);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mask    <= adc_sos_pkg::RST_ENABLE_MASK;
            r_cfg_osc     <= adc_sos_pkg::RST_OVERSAMPLE;
            r_cfg_diff_en <= 1'b0;
            r_cfg_diff_ch <= '0;
        end else if (i_cfg_valid) begin
            unique case (adc_sos_pkg::t_cfg_reg'(i_cfg_index))
                adc_sos_pkg::CFG_ENABLE_MASK: r_cfg_mask    <= i_cfg_data;
                adc_sos_pkg::CFG_OVERSAMPLE:  r_cfg_osc     <= i_cfg_data[OSC_W-1:0];
                adc_sos_pkg::CFG_DIFF_ENABLE: r_cfg_diff_en <= i_cfg_data[0];
                adc_sos_pkg::CFG_DIFF_CHAN:   r_cfg_diff_ch <= i_cfg_data[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state and handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_ch  <= '0;
            r_cnt     <= '0;
            r_active  <= 1'b0;
            r_valid   <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cur_ch <= n_cur_ch;
                r_cnt    <= n_cnt;
                r_active <= n_active;
            end
            // start wins over a write back landing in the same cycle
            if (in_acc && (in_mode == adc_sos_pkg::MODE_START)) begin
                r_valid <= '0;
            end else if (s1_adv && r_s1_wr) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_wr       <= n_s1_wr;
            r_s1_rd       <= n_s1_rd;
            r_s1_addr     <= n_s1_addr;
            r_s1_add      <= n_s1_add;
            r_s1_ctl      <= n_s1_ctl;
            r_s1_vbit     <= rd_en && r_valid[n_s1_addr];
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= sum;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {4'b0,
                           r_s1_ctl.ign,
                           (r_s1_rd ? base : ACC_W'(0)),
                           (r_s1_ctl.fin ? sum : ACC_W'(0)),
                           r_s1_ctl.fidx,
                           r_s1_ctl.fin,
                           r_s1_ctl.done,
                           r_s1_ctl.start,
                           r_s1_ctl.mux_index};
        end
    end

    // accumulator memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en && in_acc) begin
            r_acc_q <= r_acc_mem[n_s1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_wr) begin
            r_acc_mem[r_s1_addr] <= sum;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: src/adc_sos_checker.sv
// ----------------------------------------------------------------------------
// ADC scan sequencer checker
// Port-level checks on the output words of the scan sequencer.
// ----------------------------------------------------------------------------
`include "adc_scan_oversample_sequencer_unit_macros.svh"

module adc_sos_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [adc_sos_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    logic            start, done, fin, ign;
    logic [3:0]      fidx;
    logic [15:0]     fsum;

    assign start = o_m_axis_tdata[adc_sos_pkg::M_START_BIT];
    assign done  = o_m_axis_tdata[adc_sos_pkg::M_DONE_BIT];
    assign fin   = o_m_axis_tdata[adc_sos_pkg::M_FIN_BIT];
    assign ign   = o_m_axis_tdata[adc_sos_pkg::M_IGN_BIT];
    assign fidx  = o_m_axis_tdata[adc_sos_pkg::M_FIDX_LSB +: adc_sos_pkg::CH_W];
    assign fsum  = o_m_axis_tdata[adc_sos_pkg::M_FSUM_LSB +: adc_sos_pkg::ACC_W];

    // hold a stalled word
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output word changed while stalled")

    // finished fields stay zero unless a channel finished
    `ASSERT_IMPLY(a_fin_fields, i_clk, i_rst_n, o_m_axis_tvalid && !fin, (fidx == 4'd0) && (fsum == 16'd0), "finished fields set without channel_finished")

    // a finished cycle never requests another conversion
    `ASSERT_IMPLY(a_done_start, i_clk, i_rst_n, o_m_axis_tvalid && done, !start, "cycle_done with start_conversion")

    // an ignored sample changes nothing
    `ASSERT_IMPLY(a_ign_quiet, i_clk, i_rst_n, o_m_axis_tvalid && ign, !start && !fin && !done, "ignored sample reported progress")

endmodule

bind adc_scan_oversample_sequencer_unit adc_sos_checker u_adc_sos_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
